/* hdl/psbx_pkg.sv */
// ----------------------------------------------------------------------------
// psbx_pkg: shared types and constants of the point sorter
// Capacity, coordinate width and the point record handed along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package psbx_pkg;

  // capacity of one set, one cell per point
  localparam int unsigned MaxPoints = 16;

  // coordinate width, signed fixed point with 8 fraction bits
  localparam int unsigned CoordW = 32;

  // width of the point counter, able to hold MaxPoints itself
  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  // one point with its valid bit; dsp marks a point pushed out of a cell
  typedef struct packed {
    logic              vld;
    logic              dsp;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } point_t;

endpackage

`default_nettype wire

/* hdl/point_sort_by_x.sv */
// ----------------------------------------------------------------------------
// point_sort_by_x: stable ascending sort of a point set by X
// Collects points into a row of sorting cells and reads them out in order.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while loading; each enters a row of
// MaxPoints cells and ripples right one cell per cycle until it finds its
// place, so the row always holds the set sorted by X with equal X values in
// arrival order. Points beyond MaxPoints are discarded and the set is
// marked dropped. After the point carrying set_end the block stops taking
// input until the set has been read out: it waits until the last point has
// settled in the row, then shifts the row out towards cell 0 at one result
// per cycle while out_ready_i is high, the final one with out_last.
`default_nettype none

module point_sort_by_x (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [31:0] pos_x_i,
  input  wire  [31:0] pos_y_i,
  input  wire         set_end_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic        out_last_o,
  output logic        dropped_o
);

  localparam int unsigned N = psbx_pkg::MaxPoints;
  localparam int unsigned W = psbx_pkg::CntW;

  typedef enum logic [2:0] {
    StLoad   = 3'b001,
    StSettle = 3'b010,
    StEmit   = 3'b100
  } state_e;

  state_e         state_q, state_d;
  logic [W-1:0]   fill_q, fill_d;
  logic           ovf_q, ovf_d;
  logic           in_acc, out_acc, room, shift;
  logic [N-1:0]   pass_vld;
  logic           pass_any;

  psbx_pkg::point_t pass_w [N+1];
  psbx_pkg::point_t held_w [N+1];

  assign room    = fill_q < W'(N);
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign shift   = out_acc;

  // entry point of the row, end of the row reads as empty
  assign pass_w[0] = '{vld: in_acc && room, dsp: 1'b0, x: pos_x_i, y: pos_y_i};
  assign held_w[N] = '0;

  // cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    psbx_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift),
      .pass_i      (pass_w[i]),
      .next_held_i (held_w[i+1]),
      .pass_o      (pass_w[i+1]),
      .held_o      (held_w[i])
    );
    assign pass_vld[i] = pass_w[i+1].vld;
  end

  assign pass_any = |pass_vld;

  // sequencing of load, settle and readout
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (room) begin
            fill_d = fill_q + W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (set_end_i) begin
            state_d = StSettle;
          end
        end
      end
      StSettle: begin
        if (!pass_any) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_acc) begin
          fill_d = fill_q - W'(1);
          if (out_last_o) begin
            state_d = StLoad;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
    end
  end

  // handshakes and result fields, cell 0 holds the smallest point
  assign in_ready_o  = state_q == StLoad;
  assign out_valid_o = state_q == StEmit;
  assign out_x_o     = held_w[0].x;
  assign out_y_o     = held_w[0].y;
  assign out_last_o  = fill_q == W'(1);
  assign dropped_o   = ovf_q;

  // readout only starts once nothing is rippling through the row
  a_emit_settled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> !pass_any)
    else $error("point still moving during readout");

  // every result shown comes from an occupied cell
  a_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> held_w[0].vld)
    else $error("readout from empty cell");

  // the final transaction of a set leaves the block empty
  a_set_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_o) |=> (fill_q == '0 && !held_w[0].vld && !ovf_q))
    else $error("state left over after final result");

  // the point count never exceeds the row length
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= W'(N))
    else $error("point count beyond capacity");

endmodule

`default_nettype wire

/* hdl/psbx_cell.sv */
// ----------------------------------------------------------------------------
// psbx_cell: one slot of the systolic insertion sorter
// Holds one point; a new point with a smaller X displaces it, a point pushed
// out further left always takes the slot, and the held point moves on to the
// right. During readout the row shifts left.
// ----------------------------------------------------------------------------
`default_nettype none

module psbx_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 shift_i,
  input  psbx_pkg::point_t    pass_i,
  input  psbx_pkg::point_t    next_held_i,
  output psbx_pkg::point_t    pass_o,
  output psbx_pkg::point_t    held_o
);

  psbx_pkg::point_t held_q, held_d;
  psbx_pkg::point_t pass_q, pass_d;
  logic             less;

  // strictly smaller key displaces, equal keys keep arrival order
  assign less = $signed(pass_i.x) < $signed(held_q.x);

  // insert or shift, a displaced point is older than any equal key further on
  always_comb begin
    held_d     = held_q;
    pass_d     = pass_i;
    pass_d.vld = 1'b0;
    if (shift_i) begin
      held_d = next_held_i;
    end else if (pass_i.vld) begin
      if (!held_q.vld) begin
        held_d = pass_i;
      end else if (less || pass_i.dsp) begin
        held_d     = pass_i;
        pass_d     = held_q;
        pass_d.dsp = 1'b1;
      end else begin
        pass_d = pass_i;
      end
    end
  end

  // held and passing point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pass_q <= '0;
    end else begin
      held_q <= held_d;
      pass_q <= pass_d;
    end
  end

  assign pass_o = pass_q;
  assign held_o = held_q;

endmodule

`default_nettype wire

/* tb/tb_point_sort_by_x.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_sort_by_x: self-checking bench for the point sorter
// Sends point sets through the input channel and checks every sorted point
// against a local stable sort. It starts with a fixed table of sets, then
// runs random sets of mixed size, overflow included. Both channels idle at
// random, and the output side is held off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_point_sort_by_x;

  localparam logic [31:0] MinCoord = 32'h8000_0000;
  localparam logic [31:0] MaxCoord = 32'h7fff_ffff;
  localparam int unsigned NumRows  = 25;
  localparam int unsigned NumItems = 370;

  // one sorted point as it leaves the block
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
    logic        dropped;
  } sorted_pt_t;

  // one row of the directed table
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        end_mark;
    logic        typed;
    sorted_pt_t  want;
  } point_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] pos_x_i;
  logic [31:0] pos_y_i;
  logic        set_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] out_x_o;
  logic [31:0] out_y_o;
  logic        out_last_o;
  logic        dropped_o;

  // points of the open set, in arrival order
  logic [31:0] held_x [psbx_pkg::MaxPoints];
  logic [31:0] held_y [psbx_pkg::MaxPoints];
  int unsigned held_n    = 0;
  bit          held_lost = 1'b0;

  sorted_pt_t  sorted_q [$];
  int unsigned mismatches = 0;
  int unsigned sent       = 0;
  bit          tx_burst   = 1'b0;

  // single-point sets carry a typed result, the rest go through the sort
  point_row_t dir_tab [NumRows] = '{
    '{MinCoord, MinCoord, 1'b1, 1'b1, '{MinCoord, MinCoord, 1'b1, 1'b0}},
    '{MaxCoord, MaxCoord, 1'b1, 1'b1, '{MaxCoord, MaxCoord, 1'b1, 1'b0}},
    '{32'h0, 32'hffff_ffff, 1'b1, 1'b1, '{32'h0, 32'hffff_ffff, 1'b1, 1'b0}},
    // equal keys among sign extremes
    '{32'h0000_0500, 32'h1, 1'b0, 1'b0, '0},
    '{MaxCoord, 32'h2, 1'b0, 1'b0, '0},
    '{MinCoord, 32'h3, 1'b0, 1'b0, '0},
    '{32'h0000_0500, 32'h4, 1'b0, 1'b0, '0},
    '{32'hffff_fd00, 32'h5, 1'b1, 1'b0, '0},
    // full set in falling order, then a point past capacity carrying the end
    '{32'h0000_0800, 32'h100, 1'b0, 1'b0, '0},
    '{32'h0000_0700, 32'h101, 1'b0, 1'b0, '0},
    '{32'h0000_0700, 32'h102, 1'b0, 1'b0, '0},
    '{32'h0000_0600, 32'h103, 1'b0, 1'b0, '0},
    '{32'h0000_0500, 32'h104, 1'b0, 1'b0, '0},
    '{32'h0000_0500, 32'h105, 1'b0, 1'b0, '0},
    '{32'h0000_0400, 32'h106, 1'b0, 1'b0, '0},
    '{32'h0000_0300, 32'h107, 1'b0, 1'b0, '0},
    '{32'h0000_0300, 32'h108, 1'b0, 1'b0, '0},
    '{32'h0000_0200, 32'h109, 1'b0, 1'b0, '0},
    '{32'h0000_0100, 32'h10a, 1'b0, 1'b0, '0},
    '{32'h0000_0100, 32'h10b, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 32'h10c, 1'b0, 1'b0, '0},
    '{32'hffff_ff00, 32'h10d, 1'b0, 1'b0, '0},
    '{32'hffff_ff00, 32'h10e, 1'b0, 1'b0, '0},
    '{32'hffff_fe00, 32'h10f, 1'b0, 1'b0, '0},
    '{MaxCoord, 32'h110, 1'b1, 1'b0, '0}
  };

  point_sort_by_x u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .set_end_i   (set_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_last_o  (out_last_o),
    .dropped_o   (dropped_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // store a point; on the end mark sort the set stably and queue its points
  task automatic collect_point(input logic [31:0] x, input logic [31:0] y,
                               input logic end_mark);
    int unsigned i;
    int          j;
    logic [31:0] kx;
    logic [31:0] ky;
    sorted_pt_t  r;
    if (held_n < psbx_pkg::MaxPoints) begin
      held_x[held_n] = x;
      held_y[held_n] = y;
      held_n++;
    end else begin
      held_lost = 1'b1;
    end
    if (end_mark) begin
      // insertion sort, strict compare keeps equal keys in arrival order
      for (i = 1; i < held_n; i++) begin
        kx = held_x[i];
        ky = held_y[i];
        j  = int'(i) - 1;
        while (j >= 0 && $signed(held_x[j]) > $signed(kx)) begin
          held_x[j+1] = held_x[j];
          held_y[j+1] = held_y[j];
          j--;
        end
        held_x[j+1] = kx;
        held_y[j+1] = ky;
      end
      for (i = 0; i < held_n; i++) begin
        r.x       = held_x[i];
        r.y       = held_y[i];
        r.last    = (i + 1 == held_n);
        r.dropped = held_lost;
        sorted_q.push_back(r);
      end
      held_n    = 0;
      held_lost = 1'b0;
    end
  endtask

  // offer one point and hold it until the transaction completes
  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic end_mark, input logic typed,
                            input sorted_pt_t want);
    int unsigned gap;
    in_valid_i <= 1'b1;
    pos_x_i    <= x;
    pos_y_i    <= y;
    set_end_i  <= end_mark;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    // typed rows are single-point sets sent with nothing held
    if (typed) sorted_q.push_back(want);
    else       collect_point(x, y, end_mark);
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // random key: full range, a narrow band with many equal values, or an extreme
  function automatic logic [31:0] draw_key();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom;
    if (pick < 8) return (32'($urandom_range(0, 8)) - 32'd4) << 8;
    case ($urandom_range(0, 3))
      0:       return MinCoord;
      1:       return MaxCoord;
      2:       return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s expected %h, got %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // stimulus and end of run
  initial begin : stim_proc
    int unsigned i;
    int unsigned pick;
    int unsigned set_len;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    pos_x_i     <= '0;
    pos_y_i     <= '0;
    set_end_i   <= 1'b0;
    out_ready_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (i = 0; i < NumRows; i++) begin
      if (i % 8 == 0) tx_burst = ~tx_burst;
      send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].end_mark,
                 dir_tab[i].typed, dir_tab[i].want);
    end

    // random sets, mostly small, some full and some overflowing
    while (sent < NumItems) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)       set_len = $urandom_range(1, 5);
      else if (pick == 7) set_len = psbx_pkg::MaxPoints;
      else if (pick == 8) set_len = $urandom_range(psbx_pkg::MaxPoints + 1,
                                                   psbx_pkg::MaxPoints + 4);
      else                set_len = $urandom_range(6, psbx_pkg::MaxPoints - 1);
      tx_burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < set_len; i++)
        send_point(draw_key(), $urandom, (i + 1 == set_len), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // drain, then allow for any stray output
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (4 * psbx_pkg::MaxPoints) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // output side: random back-pressure, one long hold-off
  initial begin : recv_proc
    int unsigned hold;
    int unsigned rx_count;
    bit          rx_burst;
    bit          squeezed;
    sorted_pt_t  want;
    hold     = 0;
    rx_count = 0;
    rx_burst = 1'b0;
    squeezed = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        rx_count++;
        if (sorted_q.size() == 0) begin
          $display("%0t: no point expected, got x %h y %h last %b dropped %b",
                   $time, out_x_o, out_y_o, out_last_o, dropped_o);
          mismatches++;
        end else begin
          want = sorted_q.pop_front();
          check_field("out_x", want.x, out_x_o);
          check_field("out_y", want.y, out_y_o);
          check_field("out_last", 32'(want.last), 32'(out_last_o));
          check_field("dropped", 32'(want.dropped), 32'(dropped_o));
        end
        if (rx_count % 20 == 0) rx_burst = ($urandom_range(0, 2) == 0);
        hold = rx_burst ? 0 : $urandom_range(0, 16);
        // long stall so the sorter fills and blocks its input
        if (!squeezed && rx_count == 40) begin
          hold     = 300;
          squeezed = 1'b1;
        end
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
